[design/psd_pkg.sv]
`default_nettype none

package psd_pkg;

  // sample format: signed, SAMPLE_WIDTH bits, SAMPLE_WIDTH-2 fraction bits
  localparam int SAMPLE_WIDTH = 16;
  localparam int SCALE_W      = 16;
  localparam int MOD_W        = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_W        = 16;
  localparam int LLR_W        = 8;
  localparam int CNT_W        = 2;
  localparam int NUM_LANES    = 3;
  localparam int NUM_STAGES   = 7;

  // stream word widths, whole bytes
  localparam int IN_W         = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = NUM_LANES * LLR_W + CNT_W;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  // datapath widths
  localparam int COEF_W      = 16;
  localparam int ONE_SHIFT   = 16;
  localparam int SUM_W       = SAMPLE_WIDTH + 1;
  localparam int CORR_W      = SAMPLE_WIDTH + 17;
  localparam int XW          = CORR_W + 1;
  localparam int LO_W        = 17;
  localparam int HI_W        = XW - LO_W;
  localparam int PPL_W       = LO_W + SCALE_W;
  localparam int PPH_W       = HI_W + SCALE_W + 1;
  localparam int PROD_W      = XW + SCALE_W;
  localparam int ROUND_SHIFT = SAMPLE_WIDTH + 21;
  localparam int Q_W         = PROD_W - ROUND_SHIFT;
  localparam int SOFT_LIMIT  = 127;

  // 1/sqrt2 in Q0.16, the diagonal point coordinate
  localparam logic [COEF_W-1:0] DIAG_COEF = 16'd46341;

  // modulation codes
  localparam logic [MOD_W-1:0] MOD_BPSK = 2'd1;
  localparam logic [MOD_W-1:0] MOD_QPSK = 2'd2;
  localparam logic [MOD_W-1:0] MOD_8PSK = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LLR_SCALE  = 1'b1;

  localparam logic [MOD_W-1:0]   MODULATION_RESET = MOD_BPSK;
  localparam logic [SCALE_W-1:0] LLR_SCALE_RESET  = 16'd256;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic signed [CORR_W-1:0]       corr_t;
  typedef logic signed [XW-1:0]           xval_t;
  typedef logic signed [LLR_W-1:0]        llr_t;
  typedef logic        [NUM_STAGES-1:0]   stage_en_t;

endpackage

`default_nettype wire

[design/psd_corr.sv]
`default_nettype none

module psd_corr import psd_pkg::*; (
  input  wire logic             clk,
  input  wire stage_en_t        en,
  input  wire logic [MOD_W-1:0] modulation,
  input  wire sample_t          sample_re,
  input  wire sample_t          sample_im,
  output corr_t                 corr_a,
  output corr_t                 corr_b,
  output corr_t                 corr_p0,
  output corr_t                 corr_p1
);

  sample_t re_q;
  sample_t im_q;
  sum_t    op0;
  sum_t    op1;
  sum_t    op0_next;
  sum_t    op1_next;

  logic signed [SUM_W+COEF_W:0] prod0;
  logic signed [SUM_W+COEF_W:0] prod1;

  // qpsk scales the raw axes, 8psk the diagonal sums
  always_comb begin
    if (modulation == MOD_QPSK) begin
      op0_next = SUM_W'(sample_re);
      op1_next = SUM_W'(sample_im);
    end else begin
      op0_next = SUM_W'(sample_re) + SUM_W'(sample_im);
      op1_next = SUM_W'(sample_re) - SUM_W'(sample_im);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      re_q <= sample_re;
      im_q <= sample_im;
      op0  <= op0_next;
      op1  <= op1_next;
    end
  end

  always_comb begin
    prod0 = op0 * $signed({1'b0, DIAG_COEF});
    prod1 = op1 * $signed({1'b0, DIAG_COEF});
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      corr_a  <= CORR_W'(re_q) <<< ONE_SHIFT;
      corr_b  <= CORR_W'(im_q) <<< ONE_SHIFT;
      corr_p0 <= $signed(prod0[CORR_W-1:0]);
      corr_p1 <= $signed(prod1[CORR_W-1:0]);
    end
  end

endmodule

`default_nettype wire

[design/psd_max.sv]
`default_nettype none

module psd_max import psd_pkg::*; (
  input  wire logic             clk,
  input  wire stage_en_t        en,
  input  wire logic [MOD_W-1:0] modulation,
  input  wire corr_t            corr_a,
  input  wire corr_t            corr_b,
  input  wire corr_t            corr_p0,
  input  wire corr_t            corr_p1,
  output xval_t                 x [NUM_LANES]
);

  function automatic corr_t max4(corr_t w, corr_t v, corr_t y, corr_t z);
    corr_t m1;
    corr_t m2;
    m1 = (w > v) ? w : v;
    m2 = (y > z) ? y : z;
    return (m1 > m2) ? m1 : m2;
  endfunction

  corr_t na;
  corr_t nb;
  corr_t np0;
  corr_t np1;

  // best bit-0 and bit-1 correlation per bit, msb first
  corr_t best0 [NUM_LANES];
  corr_t best1 [NUM_LANES];
  corr_t a_q;
  corr_t p0_q;
  corr_t p1_q;

  xval_t x_next [NUM_LANES];

  always_comb begin
    na  = -corr_a;
    nb  = -corr_b;
    np0 = -corr_p0;
    np1 = -corr_p1;
  end

  // point order by angle: a, p0, b, -p1, -a, -p0, -b, p1
  always_ff @(posedge clk) begin
    if (en[2]) begin
      best0[0] <= max4(corr_a, corr_p0, corr_b, np1);
      best1[0] <= max4(na, np0, nb, corr_p1);
      best0[1] <= max4(corr_a, corr_p0, nb, corr_p1);
      best1[1] <= max4(corr_b, np1, na, np0);
      best0[2] <= max4(corr_a, np1, na, corr_p1);
      best1[2] <= max4(corr_p0, corr_b, np0, nb);
      a_q      <= corr_a;
      p0_q     <= corr_p0;
      p1_q     <= corr_p1;
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      x_next[l] = '0;
    end
    if (modulation == MOD_8PSK) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        x_next[l] = XW'(best0[l]) - XW'(best1[l]);
      end
    end else if (modulation == MOD_QPSK) begin
      x_next[0] = XW'(p0_q) <<< 1;
      x_next[1] = XW'(p1_q) <<< 1;
    end else begin
      x_next[0] = XW'(a_q) <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        x[l] <= x_next[l];
      end
    end
  end

endmodule

`default_nettype wire

[design/psd_scale.sv]
`default_nettype none

module psd_scale import psd_pkg::*; (
  input  wire logic               clk,
  input  wire stage_en_t          en,
  input  wire logic [SCALE_W-1:0] llr_scale,
  input  wire xval_t              x [NUM_LANES],
  output llr_t                    llr [NUM_LANES]
);

  localparam logic signed [Q_W:0] Q_MAX   = (Q_W + 1)'(SOFT_LIMIT);
  localparam logic signed [Q_W:0] Q_MIN   = -Q_MAX;
  localparam llr_t                LLR_MAX = LLR_W'(SOFT_LIMIT);
  localparam llr_t                LLR_MIN = -LLR_MAX;

  logic        [PPL_W-1:0]  pp_lo [NUM_LANES];
  logic signed [PPH_W-1:0]  pp_hi [NUM_LANES];
  logic signed [PROD_W-1:0] prod  [NUM_LANES];
  llr_t                     llr_next [NUM_LANES];

  logic signed [Q_W-1:0]         q;
  logic        [ROUND_SHIFT-1:0] rem;
  logic                          up;
  logic signed [Q_W:0]           qr;

  // partial products, low part unsigned, high part signed
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        pp_lo[l] <= PPL_W'(x[l][LO_W-1:0]) * PPL_W'(llr_scale);
        pp_hi[l] <= PPH_W'($signed(x[l][XW-1:LO_W])) * $signed({1'b0, llr_scale});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        prod[l] <= ({{(PROD_W - PPH_W){pp_hi[l][PPH_W-1]}}, pp_hi[l]} <<< LO_W)
                   + $signed({{(PROD_W - PPL_W){1'b0}}, pp_lo[l]});
      end
    end
  end

  // round to nearest, ties to even, then clamp
  always_comb begin
    q   = '0;
    rem = '0;
    up  = 1'b0;
    qr  = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      q   = $signed(prod[l][PROD_W-1:ROUND_SHIFT]);
      rem = prod[l][ROUND_SHIFT-1:0];
      up  = rem[ROUND_SHIFT-1] && ((|rem[ROUND_SHIFT-2:0]) || q[0]);
      qr  = $signed({q[Q_W-1], q}) + $signed({{Q_W{1'b0}}, up});
      if (qr > Q_MAX) begin
        llr_next[l] = LLR_MAX;
      end else if (qr < Q_MIN) begin
        llr_next[l] = LLR_MIN;
      end else begin
        llr_next[l] = qr[LLR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        llr[l] <= llr_next[l];
      end
    end
  end

endmodule

`default_nettype wire

[design/psk_soft_demapper_core.sv]
// max-log soft demapper for bpsk, qpsk and gray-labelled 8psk
//
// s_* channel: one received symbol per transfer, re in s_tdata[15:0] and
// im in s_tdata[31:16] (signed, two fraction bits short of full width),
// s_tlast marks the last symbol of a frame.
// m_* channel: one result per symbol, three signed 8-bit soft values
// (msb first, unused ones are zero) plus the count of valid values;
// m_tlast is the copied frame flag.
// cfg port: cfg_we writes cfg_data to register cfg_index
// (0 modulation, 1 llr_scale in q8.8); write only while the pipe is empty.
//
// throughput: one symbol per clock while m_tready is high, set by the seven-stage
// pipeline (input/axis mux, correlation multiply, max search, lane select,
// partial products, product sum, round and clamp into the output register).
// reset (rst, synchronous) empties the pipe and loads bpsk and scale 1.0.
// when m_tready is low the result holds; bubbles still close up, and
// s_tready drops only once every stage holds a valid symbol.
`default_nettype none

module psk_soft_demapper_core import psd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // config write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // symbol input
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [IN_W-1:0]      s_tdata,   // sample_re, sample_im
  input  wire logic                 s_tlast,   // frame_end
  // soft value output
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_W-1:0]          m_tdata,   // llr_first, llr_second, llr_third,
                                               // llr_count, zero pad
  output logic                      m_tlast    // frame_end_out
);

  // config registers
  logic [MOD_W-1:0]   modulation;
  logic [SCALE_W-1:0] llr_scale;

  // per-stage valid bits and the frame flag riding along
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] last_pipe;
  stage_en_t             en;

  sample_t sample_re;
  sample_t sample_im;
  corr_t   corr_a;
  corr_t   corr_b;
  corr_t   corr_p0;
  corr_t   corr_p1;
  xval_t   x   [NUM_LANES];
  llr_t    llr [NUM_LANES];

  logic [CNT_W-1:0] llr_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulation <= MODULATION_RESET;
      llr_scale  <= LLR_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULATION: modulation <= cfg_data[MOD_W-1:0];
        REG_LLR_SCALE:  llr_scale  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      last_pipe[0] <= s_tlast;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        last_pipe[k] <= last_pipe[k-1];
      end
    end
  end

  assign sample_re = $signed(s_tdata[SAMPLE_WIDTH-1:0]);
  assign sample_im = $signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);

  // stages 0-1: axis select and correlation against the point coordinates
  psd_corr u_corr (
    .clk        (clk),
    .en         (en),
    .modulation (modulation),
    .sample_re  (sample_re),
    .sample_im  (sample_im),
    .corr_a     (corr_a),
    .corr_b     (corr_b),
    .corr_p0    (corr_p0),
    .corr_p1    (corr_p1)
  );

  // stages 2-3: best bit-0/bit-1 correlation, per-lane value select
  psd_max u_max (
    .clk        (clk),
    .en         (en),
    .modulation (modulation),
    .corr_a     (corr_a),
    .corr_b     (corr_b),
    .corr_p0    (corr_p0),
    .corr_p1    (corr_p1),
    .x          (x)
  );

  // stages 4-6: scale multiply, round, clamp; last stage is the output register
  psd_scale u_scale (
    .clk       (clk),
    .en        (en),
    .llr_scale (llr_scale),
    .x         (x),
    .llr       (llr)
  );

  // modulation zero counts as bpsk
  always_comb begin
    unique case (modulation)
      MOD_QPSK: llr_count = CNT_W'(2);
      MOD_8PSK: llr_count = CNT_W'(3);
      default:  llr_count = CNT_W'(1);
    endcase
  end

  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tlast  = last_pipe[NUM_STAGES-1];
  assign m_tdata  = {{(OUT_W - OUT_FIELDS_W){1'b0}}, llr_count, llr[2], llr[1], llr[0]};

endmodule

`default_nettype wire
